// ----- rtl/dwcd_pkg.sv -----
// ============================================================================
// dwcd_pkg
// Shared widths, blank code and seven-segment digit table for the debounced
// weighted counter display.
// ============================================================================
package dwcd_pkg;

    localparam int COUNT_W = 10;
    localparam int SEG_W   = 8;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SEG_W-1:0]   seg_t;

    localparam seg_t BLANK_CODE = 8'hFF;

    // active-low codes, bits g..a, for digits 0..9
    function automatic seg_t digit_to_seg(input logic [3:0] digit);
        seg_t code;
        unique case (digit)
            4'd0:    code = 8'b1100_0000;
            4'd1:    code = 8'b1111_1001;
            4'd2:    code = 8'b1010_0100;
            4'd3:    code = 8'b1011_0000;
            4'd4:    code = 8'b1001_1001;
            4'd5:    code = 8'b1001_0010;
            4'd6:    code = 8'b1000_0010;
            4'd7:    code = 8'b1111_1000;
            4'd8:    code = 8'b1000_0000;
            4'd9:    code = 8'b1001_1000;
            default: code = BLANK_CODE;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/dwcd_lane.sv -----
// ============================================================================
// dwcd_lane
// Shift-history debouncer for one button: fires once on a pressed sample
// followed by QUIET_SAMPLES released samples.
// ============================================================================
module dwcd_lane
    import dwcd_pkg::*;
#(
    parameter int QUIET_SAMPLES = 12
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic sample_en,
    input  logic pressed,
    output logic fire
);

    localparam int HIST_W = QUIET_SAMPLES + 1;
    localparam logic [HIST_W-1:0] FIRE_PATTERN = {1'b1, {QUIET_SAMPLES{1'b0}}};

    logic [HIST_W-1:0] hist_reg;
    logic [HIST_W-1:0] hist_next;

    assign hist_next = {hist_reg[HIST_W-2:0], pressed};
    assign fire      = sample_en && (hist_next == FIRE_PATTERN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else if (sample_en)
        begin
            hist_reg <= hist_next;
        end
    end

endmodule

// ----- rtl/dwcd_seg.sv -----
// ============================================================================
// dwcd_seg
// Decimal split of the 10-bit count with leading-zero blanking and
// seven-segment encoding of each digit.
// ============================================================================
module dwcd_seg
    import dwcd_pkg::*;
(
    input  count_t count,
    output seg_t   seg_ones,
    output seg_t   seg_tens,
    output seg_t   seg_hundreds,
    output seg_t   seg_thousands
);

    // reciprocal multiplies, exact over 0..1023
    logic [17:0] mul_tens;
    logic [15:0] mul_hund;
    logic [6:0]  q10;
    logic [3:0]  q100;
    logic [3:0]  d_ones;
    logic [3:0]  d_tens;
    logic [3:0]  d_hund;
    logic [10:0] ten_q10;
    logic [7:0]  ten_q100;

    assign mul_tens = 18'(count) * 18'd205;
    assign mul_hund = 16'(count) * 16'd41;
    assign q10      = mul_tens[17:11];
    assign q100     = mul_hund[15:12];

    assign ten_q10  = 11'(q10) * 11'd10;
    assign ten_q100 = 8'(q100) * 8'd10;

    assign d_ones = 4'(11'(count) - ten_q10);
    assign d_tens = 4'(8'(q10) - ten_q100);
    assign d_hund = (q100 >= 4'd10) ? (q100 - 4'd10) : q100;

    assign seg_ones      = digit_to_seg(d_ones);
    assign seg_tens      = (count >= count_t'(10))   ? digit_to_seg(d_tens) : BLANK_CODE;
    assign seg_hundreds  = (count >= count_t'(100))  ? digit_to_seg(d_hund) : BLANK_CODE;
    assign seg_thousands = (count >= count_t'(1000)) ? digit_to_seg(4'd1)   : BLANK_CODE;

endmodule

// ----- rtl/debounced_weighted_counter_display_unit.sv -----
// ============================================================================
// debounced_weighted_counter_display_unit
// Per-button debounce, weighted event count and four-digit seven-segment codes.
// ============================================================================
// Takes one beat of raw active-low button levels per clock while item_stall
// is low and returns one result beat per input beat, in order. Sustained rate
// is one beat per cycle while the sink does not stall. The count updates at
// the input accept edge. Digit split and encode of that count go into the
// output register when it is empty or being emptied, and result valid rises
// with that load. The read-modify-write of the running count, fed by all
// debounce lanes at once, sets the sustained rate. Segment codes are active
// low; blanked digits and the colon slot read 0xFF.
module debounced_weighted_counter_display_unit
    import dwcd_pkg::*;
#(
    parameter int NUM_BUTTONS   = 8,
    parameter int QUIET_SAMPLES = 12
)
(
    input  logic       clk,
    input  logic       rst_n,

    // sample beat
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] pin_levels,

    // result beat
    output logic       result_valid,
    input  logic       result_stall,
    output count_t     count_value,
    output seg_t       seg_ones,
    output seg_t       seg_tens,
    output seg_t       seg_colon,
    output seg_t       seg_hundreds,
    output seg_t       seg_thousands
);

    localparam int PIN_W = 8;

    // pipeline control
    logic item_accept;
    logic out_load;
    logic s1_valid_reg;
    logic s1_valid_next;
    logic result_valid_reg;
    logic result_valid_next;

    // lanes and merge
    logic [NUM_BUTTONS-1:0] pressed_vec;
    logic [NUM_BUTTONS-1:0] fire_vec;
    count_t count_reg;
    count_t count_next;

    // encoded digits
    seg_t enc_ones;
    seg_t enc_tens;
    seg_t enc_hund;
    seg_t enc_thou;

    count_t count_value_reg;
    seg_t   seg_ones_reg;
    seg_t   seg_tens_reg;
    seg_t   seg_hund_reg;
    seg_t   seg_thou_reg;

    // stage one holds a counted beat until the output register can take it
    assign out_load    = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall  = s1_valid_reg && !out_load;
    assign item_accept = item_valid && !item_stall;

    // one debounce lane per button; buttons with no pin read as released
    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_lane
        if (i < PIN_W)
        begin : g_pin
            assign pressed_vec[i] = ~pin_levels[i];
        end
        else
        begin : g_nopin
            assign pressed_vec[i] = 1'b0;
        end

        dwcd_lane #(
            .QUIET_SAMPLES (QUIET_SAMPLES)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .sample_en (item_accept),
            .pressed   (pressed_vec[i]),
            .fire      (fire_vec[i])
        );
    end

    // merge: lane i weighs 2^i, so the fire vector itself is the increment
    assign count_next = count_reg + COUNT_W'(fire_vec);

    // count_reg is stage one's payload: it only moves on accept, and no
    // accept happens while stage one is held
    dwcd_seg u_seg (
        .count         (count_reg),
        .seg_ones      (enc_ones),
        .seg_tens      (enc_tens),
        .seg_hundreds  (enc_hund),
        .seg_thousands (enc_thou)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg && result_stall;
        if (out_load)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            count_reg        <= '0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            if (item_accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            count_value_reg <= count_reg;
            seg_ones_reg    <= enc_ones;
            seg_tens_reg    <= enc_tens;
            seg_hund_reg    <= enc_hund;
            seg_thou_reg    <= enc_thou;
        end
    end

    assign result_valid  = result_valid_reg;
    assign count_value   = count_value_reg;
    assign seg_ones      = seg_ones_reg;
    assign seg_tens      = seg_tens_reg;
    assign seg_colon     = BLANK_CODE;
    assign seg_hundreds  = seg_hund_reg;
    assign seg_thousands = seg_thou_reg;

endmodule

// ----- bench/tb_debounced_weighted_counter_display_unit.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_debounced_weighted_counter_display_unit
// Self-checking bench for the debounced weighted counter display.
// ============================================================================
// A table of directed samples covers reset, all buttons pressed at once and a
// single weighted button. Random press/quiet sequences follow, in three idle
// phases, with long sink hold-offs. Every result beat is checked field by field:
// pinned directed rows against their typed-in display, all others against a
// cycle-free model of the debounce lanes, the weighted tally and the digit encoder.
module tb_debounced_weighted_counter_display_unit;
    import dwcd_pkg::*;

    localparam int NUM_BUTTONS   = 8;
    localparam int QUIET_SAMPLES = 12;
    localparam int HIST_W        = QUIET_SAMPLES + 1;

    // one pressed sample followed by a full quiet window
    localparam logic [HIST_W-1:0] FIRE_PATTERN = {1'b1, {QUIET_SAMPLES{1'b0}}};

    localparam int HOLD_CYCLES  = 40;   // long sink hold-off, fills the pipe
    localparam int DRAIN_CYCLES = 8;    // wait after the last expected display for a stray beat
    localparam int PHASE_ITEMS  = 310;  // fewest random samples per idle phase

    // active-low digit codes, bits g..a
    localparam seg_t SEG_CODE [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h98
    };

    typedef struct packed {
        count_t count;
        seg_t   ones;
        seg_t   tens;
        seg_t   colon;
        seg_t   hundreds;
        seg_t   thousands;
    } display_t;

    typedef struct packed {
        logic [7:0] pins;
        logic       pinned;     // expected display typed in below
        display_t   want;
    } sample_row_t;

    // displays that can be read straight off the digit table
    localparam display_t SHOWS_0 =
        '{10'd0, SEG_CODE[0], BLANK_CODE, BLANK_CODE, BLANK_CODE, BLANK_CODE};
    localparam display_t SHOWS_255 =
        '{10'd255, SEG_CODE[5], SEG_CODE[5], BLANK_CODE, SEG_CODE[2], BLANK_CODE};
    localparam display_t SHOWS_383 =
        '{10'd383, SEG_CODE[3], SEG_CODE[8], BLANK_CODE, SEG_CODE[3], BLANK_CODE};

    // directed part: reset value, every button in one press, then button 7 alone
    localparam int DIRECTED_N = 27;
    localparam sample_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        '{8'hFF, 1'b1, SHOWS_0},    // nothing pressed, count shows a lone zero
        '{8'h00, 1'b1, SHOWS_0},    // all eight pressed, nothing fires yet
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b1, SHOWS_255},  // twelfth quiet sample: all fire, 1+2+..+128
        '{8'h7F, 1'b0, '0},         // top button only
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b1, SHOWS_383}   // weight 128 lands on top of 255
    };

    logic   clk = 1'b0;
    logic   rst_n;
    logic   item_valid;
    logic   item_stall;
    logic   [7:0] pin_levels;
    logic   result_valid;
    logic   result_stall;
    count_t count_value;
    seg_t   seg_ones;
    seg_t   seg_tens;
    seg_t   seg_colon;
    seg_t   seg_hundreds;
    seg_t   seg_thousands;

    // model state: one shift history per button plus the weighted tally
    logic [HIST_W-1:0] debounce_hist [NUM_BUTTONS];
    count_t            tally;

    display_t    expected_displays [$];
    int unsigned mismatches   = 0;
    int unsigned samples_sent = 0;

    // idle knobs, changed by the main sequence between phases
    int unsigned src_gap_pct    = 0;
    int unsigned sink_stall_pct = 0;
    bit          hold_req       = 1'b0;
    int unsigned stall_left     = 0;

    debounced_weighted_counter_display_unit #(
        .NUM_BUTTONS  (NUM_BUTTONS),
        .QUIET_SAMPLES(QUIET_SAMPLES)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .pin_levels   (pin_levels),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .count_value  (count_value),
        .seg_ones     (seg_ones),
        .seg_tens     (seg_tens),
        .seg_colon    (seg_colon),
        .seg_hundreds (seg_hundreds),
        .seg_thousands(seg_thousands)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shift every lane, add the weights of the lanes that fire, encode digits
    function automatic display_t advance_tally(input logic [7:0] pins);
        display_t    shown;
        int unsigned c;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            debounce_hist[i] = {debounce_hist[i][HIST_W-2:0], ~pins[i]};
            if (debounce_hist[i] == FIRE_PATTERN)
                tally = tally + count_t'(1 << i);   // wraps at 1024
        end
        c               = tally;
        shown.count     = tally;
        shown.ones      = SEG_CODE[c % 10];
        shown.tens      = (c >= 10)   ? SEG_CODE[(c / 10) % 10]   : BLANK_CODE;
        shown.colon     = BLANK_CODE;
        shown.hundreds  = (c >= 100)  ? SEG_CODE[(c / 100) % 10]  : BLANK_CODE;
        shown.thousands = (c >= 1000) ? SEG_CODE[(c / 1000) % 10] : BLANK_CODE;
        return shown;
    endfunction

    function automatic void compare_field(input string field, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // one sample beat: random gap, hold until taken, then record the prediction
    task automatic send_sample(input logic [7:0] pins, input logic pinned,
                               input display_t want);
        display_t predicted;
        while ($urandom_range(0, 99) < src_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        pin_levels <= pins;
        do
            @(posedge clk);
        while (item_stall);
        predicted = advance_tally(pins);
        expected_displays.push_back(pinned ? want : predicted);
        samples_sent++;
    endtask

    task automatic send_pins(input logic [7:0] pins);
        send_sample(pins, 1'b0, '0);
    endtask

    // stop offering and let every outstanding display come back
    task automatic wait_for_results;
        item_valid <= 1'b0;
        while (expected_displays.size() != 0)
            @(posedge clk);
    endtask

    // mostly clean presses with a full quiet window, plus noise and cut-short windows
    task automatic run_random(input int unsigned how_many);
        int unsigned stop_at;
        int unsigned kind;
        int unsigned hold;
        int unsigned quiet;
        logic [7:0]  mask;
        stop_at = samples_sent + how_many;
        while (samples_sent < stop_at)
        begin
            kind = $urandom_range(0, 9);
            mask = 8'($urandom_range(1, 255));
            if (kind <= 6)
            begin
                // now and then aim the tally into the thousands range
                if (kind == 0 && tally >= 769 && tally < 1000)
                    mask = 8'(1000 + $urandom_range(0, 23) - tally);
                hold = $urandom_range(1, 3);
                send_pins(~mask);
                for (int k = 1; k < hold; k++)
                    send_pins(~(mask & 8'($urandom)));    // bounce while held
                quiet = $urandom_range(QUIET_SAMPLES, QUIET_SAMPLES + 4);
                for (int k = 0; k < quiet; k++)
                begin
                    if ($urandom_range(0, 6) == 0)
                        send_pins(~(8'd1 << $urandom_range(0, 7)));
                    else
                        send_pins(8'hFF);
                end
            end
            else if (kind <= 8)
            begin
                repeat ($urandom_range(1, 10))
                    send_pins(8'($urandom));
            end
            else
            begin
                // quiet window cut short by a second press
                send_pins(~mask);
                repeat ($urandom_range(1, QUIET_SAMPLES - 1))
                    send_pins(8'hFF);
                send_pins(~mask);
            end
        end
    endtask

    // result side: check each taken beat, then pick next cycle's stall
    initial
    begin
        display_t want;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                if (expected_displays.size() == 0)
                begin
                    $display("%0t ns: result beat with nothing expected, count %0h",
                             $time, count_value);
                    mismatches++;
                end
                else
                begin
                    want = expected_displays.pop_front();
                    compare_field("count_value",   want.count,     count_value);
                    compare_field("seg_ones",      want.ones,      seg_ones);
                    compare_field("seg_tens",      want.tens,      seg_tens);
                    compare_field("seg_colon",     want.colon,     seg_colon);
                    compare_field("seg_hundreds",  want.hundreds,  seg_hundreds);
                    compare_field("seg_thousands", want.thousands, seg_thousands);
                end
            end
            // long hold-off while the source keeps pushing
            if (stall_left != 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else if (hold_req)
            begin
                hold_req     = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(0, 99) < sink_stall_pct);
        end
    end

    // main sequence
    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        pin_levels   = 8'hFF;
        tally        = '0;
        for (int i = 0; i < NUM_BUTTONS; i++)
            debounce_hist[i] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase one: source rarely idle, sink stalls most cycles
        src_gap_pct    = 7;
        sink_stall_pct = 70;
        for (int r = 0; r < DIRECTED_N; r++)
            send_sample(DIRECTED_ROWS[r].pins, DIRECTED_ROWS[r].pinned,
                        DIRECTED_ROWS[r].want);
        hold_req = 1'b1;
        run_random(PHASE_ITEMS);
        wait_for_results;

        // phase two: source idles most cycles, sink rarely stalls
        src_gap_pct    = 70;
        sink_stall_pct = 7;
        run_random(PHASE_ITEMS);
        wait_for_results;

        // phase three: full rate both ways, one more long hold-off
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        hold_req       = 1'b1;
        run_random(PHASE_ITEMS);
        wait_for_results;

        // catch any stray beat after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_displays.size() == 0)
            $display("** debounced_weighted_counter_display_unit: PASSED **");
        else
            $display("** debounced_weighted_counter_display_unit: FAILED **");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #200000;
        $display("** debounced_weighted_counter_display_unit: FAILED **");
        $finish;
    end

endmodule

// ----- debounced_weighted_counter_display_unit.f -----
rtl/dwcd_pkg.sv
rtl/dwcd_lane.sv
rtl/dwcd_seg.sv
rtl/debounced_weighted_counter_display_unit.sv
bench/tb_debounced_weighted_counter_display_unit.sv
